[src/sha256_stream_hasher_defines.svh]
// assertion macros shared by the sha-256 hasher rtl
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SHA_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define SHA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[src/sha256_pkg.sv]
// types, constants and round functions of the sha-256 hasher
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_set_t;

  localparam hash_set_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [7:0] PAD_ZERO   = 8'h00;
  localparam logic [5:0] PAD_END    = 6'd56;
  localparam logic [5:0] LAST_FILL  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_INDEX = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_UPDATE,
    S_OUT
  } fsm_state_t;

  // controls for the block / schedule window
  typedef struct packed {
    logic       load;
    logic [7:0] byte_in;
    logic       step;
    logic       expand;
  } sched_ctl_t;

  // controls for the round unit
  typedef struct packed {
    logic       init;
    logic       step;
    logic [5:0] round;
  } round_ctl_t;

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
    endcase
    round_k = k;
  endfunction

endpackage
`default_nettype wire

[src/sha256_sched.sv]
// block buffer and rolling message schedule window
`timescale 1ns / 1ps
`default_nettype none
module sha256_sched (
  input  wire                     clk,
  input  sha256_pkg::sched_ctl_t  ctl,
  output sha256_pkg::word_t       w
);
  import sha256_pkg::*;

  word_t win [16];
  word_t new_word;

  // from round 16 on, win[0]..win[15] hold w[t-16]..w[t-1]; in earlier rounds win[0] is w[t]
  always_comb begin
    if (ctl.expand) begin
      new_word = win[0] + small_sigma0(win[1]) + win[9] + small_sigma1(win[14]);
    end else begin
      new_word = win[0];
    end
  end

  assign w = new_word;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      // whole window acts as one 512-bit byte shift register
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], ctl.byte_in};
    end else if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= new_word;
    end
  end

endmodule
`default_nettype wire

[src/sha256_round.sv]
// shared compression round unit with working registers a..h
`timescale 1ns / 1ps
`default_nettype none
module sha256_round (
  input  wire                     clk,
  input  sha256_pkg::round_ctl_t  ctl,
  input  sha256_pkg::hash_set_t   hash,
  input  sha256_pkg::word_t       w,
  output sha256_pkg::hash_set_t   work
);
  import sha256_pkg::*;

  hash_set_t regs;
  word_t     ch;
  word_t     maj;
  word_t     t1;
  word_t     t2;

  always_comb begin
    ch  = (regs[4] & regs[5]) ^ (~regs[4] & regs[6]);
    maj = (regs[0] & regs[1]) ^ (regs[0] & regs[2]) ^ (regs[1] & regs[2]);
    t1  = regs[7] + big_sigma1(regs[4]) + ch + round_k(ctl.round) + w;
    t2  = big_sigma0(regs[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      regs <= hash;
    end else if (ctl.step) begin
      regs[7] <= regs[6];
      regs[6] <= regs[5];
      regs[5] <= regs[4];
      regs[4] <= regs[3] + t1;
      regs[3] <= regs[2];
      regs[2] <= regs[1];
      regs[1] <= regs[0];
      regs[0] <= t1 + t2;
    end
  end

  assign work = regs;

endmodule
`default_nettype wire

[src/sha256_stream_hasher.sv]
// top level of the byte-serial sha-256 hasher: sequencer, hash state, digest output
//
//   channel | signals                                   | moves
//   --------+-------------------------------------------+----------------------------
//   in      | in_valid, in_ready, func, data_byte       | one absorb or finish request
//   out     | out_valid, out_ready, digest_word,        | one 32-bit digest word
//           | word_index, last_word                     |
//
// absorb: the 64th byte of a block also starts compression (64 rounds on the one round unit + 1 update)
// finish: marker, then one zero byte per cycle up to byte 55 and a turn to the length,
//   8 length bytes, then compression; a marker past byte 55 first zero-fills and
//   compresses its own block; the digest then leaves as 8 words, one per accepted cycle
// rst is synchronous and restores the initial hash, zero length and empty buffer
// in_ready is high only in idle; a stalled out_ready simply holds the current word
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module sha256_stream_hasher (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         func,
  input  wire  [7:0]  data_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  fsm_state_t state;
  fsm_state_t state_next;

  hash_set_t   hash;
  hash_set_t   work;
  logic [63:0] length;
  logic [5:0]  fill;          // bytes currently in the block buffer
  logic [5:0]  round_cnt;
  logic [2:0]  out_idx;
  logic        finishing;     // a finish request is being padded
  logic        len_sent;      // the length bytes are in the final block
  logic        start;         // load working registers, begin compression
  logic        in_fire;
  logic        out_fire;
  logic [7:0]  len_byte;
  word_t       w;
  sched_ctl_t  sch;
  round_ctl_t  rnd;

  sha256_sched u_sched (
    .clk (clk),
    .ctl (sch),
    .w   (w)
  );

  sha256_round u_round (
    .clk  (clk),
    .ctl  (rnd),
    .hash (hash),
    .w    (w),
    .work (work)
  );

  // big-endian length byte for buffer position 56 + fill[2:0]
  assign len_byte = length[{~fill[2:0], 3'b000} +: 8];

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    start       = 1'b0;
    sch         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // a finish request drops the 0x80 marker straight into the buffer
          sch.load    = 1'b1;
          sch.byte_in = (func == FUNC_ABSORB) ? data_byte : PAD_MARK;
          if (fill == LAST_FILL) begin
            start      = 1'b1;
            state_next = S_ROUND;
          end else if (func == FUNC_FINISH) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (fill == PAD_END) begin
          state_next = S_LEN;
        end else begin
          sch.load    = 1'b1;
          sch.byte_in = PAD_ZERO;
          if (fill == LAST_FILL) begin
            // marker landed past byte 55: this block closes without the length
            start      = 1'b1;
            state_next = S_ROUND;
          end
        end
      end
      S_LEN: begin
        sch.load    = 1'b1;
        sch.byte_in = len_byte;
        if (fill == LAST_FILL) begin
          start      = 1'b1;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        sch.step   = 1'b1;
        sch.expand = (round_cnt[5:4] != 2'b00);
        if (round_cnt == LAST_ROUND) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!finishing) begin
          state_next = S_IDLE;
        end else if (len_sent) begin
          state_next = S_OUT;
        end else begin
          state_next = S_PAD;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready && out_idx == LAST_INDEX) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    rnd.init  = start;
    rnd.step  = (state == S_ROUND);
    rnd.round = round_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hash      <= INIT_HASH;
      length    <= '0;
      fill      <= '0;
      round_cnt <= '0;
      out_idx   <= '0;
      finishing <= 1'b0;
      len_sent  <= 1'b0;
    end else begin
      state <= state_next;
      if (sch.load) begin
        fill <= fill + 6'd1;
      end
      if (in_fire && func == FUNC_ABSORB) begin
        length <= length + 64'd8;
      end
      if (in_fire && func == FUNC_FINISH) begin
        finishing <= 1'b1;
      end
      if (state == S_LEN && fill == LAST_FILL) begin
        len_sent <= 1'b1;
      end
      if (start) begin
        round_cnt <= '0;
      end else if (state == S_ROUND) begin
        round_cnt <= round_cnt + 6'd1;
      end
      if (state == S_UPDATE) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + work[i];
        end
      end
      if (out_fire) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == LAST_INDEX) begin
          // digest delivered: start the next message
          hash      <= INIT_HASH;
          length    <= '0;
          fill      <= '0;
          finishing <= 1'b0;
          len_sent  <= 1'b0;
        end
      end
    end
  end

  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == LAST_INDEX);

  `SHA_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input taken while digest pending")
  `SHA_ASSERT_NOW(a_block_full, (state != S_ROUND) && (state_next == S_ROUND),
                  (sch.load && fill == LAST_FILL), "compression started on a partial block")
  `SHA_ASSERT_NEXT(a_round_end, (state == S_ROUND) && (round_cnt == LAST_ROUND),
                   (state == S_UPDATE), "round count overran")
  `SHA_ASSERT_NEXT(a_reinit, out_fire && last_word,
                   (hash == INIT_HASH) && (length == 64'd0) && (fill == 6'd0),
                   "state not reinitialized after digest")
  `SHA_ASSERT_NOW(a_out_ready_len, state == S_OUT, (len_sent && finishing && fill == 6'd0),
                  "digest shown before length block")

endmodule
`default_nettype wire

[dv/testbench.sv]
// self-checking testbench of the byte-serial sha-256 hasher with a digest scoreboard
`timescale 1ns / 1ps
module testbench;
  import sha256_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned ITEM_TARGET  = 370;
  localparam int unsigned DRAIN_CYCLES = 80;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam int unsigned LEN_SLOT = 56;

  // message lengths around the padding and block boundaries
  localparam int unsigned EDGE_LENGTHS [13] = '{
    0, 1, 54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 128
  };

  localparam word_t HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // running sha-256 of the request stream and the digest words still owed
  class digest_scoreboard;
    typedef struct {
      word_t      word;
      logic [2:0] index;
      logic       last;
    } digest_entry_t;

    word_t         chain [8];
    logic [63:0]   msg_bits;
    logic [7:0]    block [64];
    int unsigned   fill;
    digest_entry_t expected_words [$];
    int unsigned   mismatch_count;

    function new();
      mismatch_count = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = HASH_IV[i];
      msg_bits = '0;
      fill = 0;
    endfunction

    function word_t rotr(word_t v, int unsigned n);
      return (v >> n) | (v << (32 - n));
    endfunction

    function void compress();
      word_t sched [64];
      word_t a, b, c, d, e, f, g, h;
      word_t t1, t2, x, y;
      for (int t = 0; t < 16; t++)
        sched[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        x = sched[t-15];
        y = sched[t-2];
        sched[t] = sched[t-16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + sched[t-7]
                   + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_K[t] + sched[t];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    // an absorb adds one byte; a finish pads, compresses and owes eight words
    function void note_request(logic req_func, logic [7:0] req_byte);
      int unsigned pos;
      if (req_func == FUNC_ABSORB) begin
        block[fill] = req_byte;
        msg_bits += 64'd8;
        fill = (fill + 1) % 64;
        if (fill == 0) compress();
      end else begin
        pos = fill;
        block[pos] = PAD_BYTE;
        pos++;
        // no room left for the length: close this block and start another
        if (pos > LEN_SLOT) begin
          for (int i = pos; i < 64; i++) block[i] = 8'h00;
          compress();
          pos = 0;
        end
        for (int i = pos; i < LEN_SLOT; i++) block[i] = 8'h00;
        for (int i = 0; i < 8; i++) block[63-i] = msg_bits[8*i +: 8];
        compress();
        for (int i = 0; i < 8; i++)
          expected_words.push_back('{chain[i], 3'(i), (i == 7)});
        restart();
      end
    endfunction

    task check_word(word_t got_word, logic [2:0] got_index, logic got_last);
      digest_entry_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("digest word %h index %0d with none expected", got_word, got_index));
        return;
      end
      want = expected_words.pop_front();
      if (got_word !== want.word)
        report($sformatf("digest_word %h, expected %h", got_word, want.word));
      if (got_index !== want.index)
        report($sformatf("word_index %0d, expected %0d", got_index, want.index));
      if (got_last !== want.last)
        report($sformatf("last_word %b, expected %b on index %0d", got_last, want.last,
                         want.index));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int unsigned      cycle_count = 0;
  int unsigned      sent_count = 0;
  digest_scoreboard digest_check = new();

  sha256_stream_hasher u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sha256_stream_hasher] ERROR");
      $finish;
    end
  end

  // valid stays high across back-to-back requests
  task automatic send_request(input logic req_func, input logic [7:0] req_byte,
                              input bit steady);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= req_func;
    data_byte <= req_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    digest_check.note_request(req_func, req_byte);
    sent_count++;
  endtask

  // digest sink with random stalls and stretches of none
  initial begin : digest_sink
    int unsigned stall;
    bit steady;
    steady = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      digest_check.check_word(digest_word, word_index, last_word);
    end
  end

  initial begin : stimulus
    int unsigned msg_len;
    bit steady;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty message, and a finish whose byte must be ignored
    send_request(FUNC_FINISH, 8'h00, 1'b0);
    send_request(FUNC_FINISH, 8'hff, 1'b0);
    // "abc"
    send_request(FUNC_ABSORB, 8'h61, 1'b0);
    send_request(FUNC_ABSORB, 8'h62, 1'b0);
    send_request(FUNC_ABSORB, 8'h63, 1'b0);
    send_request(FUNC_FINISH, 8'h5a, 1'b0);
    // byte extremes, sent back to back
    send_request(FUNC_ABSORB, 8'h00, 1'b1);
    send_request(FUNC_ABSORB, 8'hff, 1'b1);
    send_request(FUNC_ABSORB, PAD_BYTE, 1'b1);
    send_request(FUNC_FINISH, 8'ha5, 1'b1);

    // random messages, short ones mostly, some at the block edges
    while (sent_count < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0)
        msg_len = EDGE_LENGTHS[$urandom_range(0, 12)];
      else
        msg_len = $urandom_range(0, 12);
      repeat (msg_len) send_request(FUNC_ABSORB, 8'($urandom_range(0, 255)), steady);
      send_request(FUNC_FINISH, 8'($urandom_range(0, 255)), steady);
    end
    in_valid <= 1'b0;

    while (digest_check.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digest_check.mismatch_count == 0)
      $display("[sha256_stream_hasher] OK");
    else
      $display("[sha256_stream_hasher] ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/sha256_pkg.sv
src/sha256_sched.sv
src/sha256_round.sv
src/sha256_stream_hasher.sv
dv/testbench.sv
